### hdl/ps2sm_pkg.sv
// ----------------------------------------------------------------------------
// ps2sm_pkg
// Shared types and constants of the PS/2 to serial mouse translator.
// ----------------------------------------------------------------------------
package ps2sm_pkg;

    localparam int C_GREETING_LENGTH = 61;
    localparam int C_TABLE_DEPTH     = 64;
    localparam int C_IDX_W           = $clog2(C_TABLE_DEPTH);
    localparam int C_LEN_W           = C_IDX_W + 1;

    // input item codes
    localparam logic [1:0] C_FUNC_BYTE = 2'd0;
    localparam logic [1:0] C_FUNC_TICK = 2'd1;
    localparam logic [1:0] C_FUNC_LINE = 2'd2;

    // protocol_mode codes
    localparam logic C_MODE_THREE_BTN = 1'b0;
    localparam logic C_MODE_EXTENDED  = 1'b1;

    // byte position codes
    localparam logic [1:0] C_POS_BUTTONS = 2'd0;
    localparam logic [1:0] C_POS_X       = 2'd1;
    localparam logic [1:0] C_POS_Y       = 2'd2;

    // two-byte greeting of the three-button format
    localparam logic [6:0] C_HELLO_0 = 7'h4D;
    localparam logic [6:0] C_HELLO_1 = 7'h33;

    // identification string of the extended format
    localparam logic [6:0] C_GREET [C_TABLE_DEPTH] = '{
        7'h4D, 7'h5A, 7'h40, 7'h00, 7'h00, 7'h00, 7'h08, 7'h01,
        7'h24, 7'h25, 7'h2D, 7'h23, 7'h10, 7'h10, 7'h10, 7'h11,
        7'h3C, 7'h3C, 7'h2D, 7'h2F, 7'h35, 7'h33, 7'h25, 7'h3C,
        7'h30, 7'h2E, 7'h30, 7'h10, 7'h26, 7'h10, 7'h21, 7'h3C,
        7'h25, 7'h2D, 7'h23, 7'h00, 7'h33, 7'h23, 7'h32, 7'h2F,
        7'h2C, 7'h2C, 7'h29, 7'h2E, 7'h27, 7'h00, 7'h33, 7'h25,
        7'h32, 7'h29, 7'h21, 7'h2C, 7'h00, 7'h2D, 7'h2F, 7'h35,
        7'h33, 7'h25, 7'h21, 7'h15, 7'h09, 7'h00, 7'h00, 7'h00
    };

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
        logic cfg_wr;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic at_last;
        logic out_free;
    } t_sts;

endpackage

### hdl/ps2sm_ctrl.sv
// ----------------------------------------------------------------------------
// ps2sm_ctrl
// Sequencer: takes one item, runs it through the datapath, then paces out
// the resulting bytes into the output register.
// ----------------------------------------------------------------------------
module ps2sm_ctrl import ps2sm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        o_cfg_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cfg_ready  = 1'b1;
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_SEND;
            end
            S_SEND: begin
                if (i_sts.len_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.at_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/ps2sm_dp.sv
// ----------------------------------------------------------------------------
// ps2sm_dp
// Datapath: packet assembly, motion accumulators, host state, run buffer
// and output register.
// ----------------------------------------------------------------------------
module ps2sm_dp import ps2sm_pkg::*; #(
    parameter int GREETING_LENGTH = C_GREETING_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic       i_cfg_protocol_mode,
    input  logic [1:0] i_func,
    input  logic [7:0] i_ps2_byte,
    input  logic       i_host_line_high,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [6:0] o_serial_byte,
    output logic       o_last_of_run
);

    // latched item
    logic [1:0] r_func;
    logic [7:0] r_byte;
    logic       r_line;

    // translator state
    logic        r_mode,     n_mode;
    logic [1:0]  r_pos,      n_pos;
    logic [2:0]  r_held_btn, n_held_btn;
    logic [7:0]  r_held_x,   n_held_x;
    logic [15:0] r_acc_x,    n_acc_x;
    logic [15:0] r_acc_y,    n_acc_y;
    logic [2:0]  r_cur_btn,  n_cur_btn;
    logic [2:0]  r_sent_btn, n_sent_btn;
    logic        r_sent_mid, n_sent_mid;
    logic        r_host_en,  n_host_en;
    logic        r_force,    n_force;

    // run buffer
    logic [6:0]         r_pkt [4];
    logic [6:0]         n_pkt [4];
    logic               r_greet,  n_greet;
    logic [C_LEN_W-1:0] r_len,    n_len;
    logic [C_IDX_W-1:0] r_idx;

    // output register
    logic       r_out_valid;
    logic [6:0] r_out_byte;
    logic       r_out_last;

    logic [16:0] sum_x;
    logic [16:0] sum_y;
    logic        x_hi, x_lo, y_hi, y_lo;
    logic [7:0]  cx, cy;
    logic [15:0] rem_x, rem_y;
    logic        report;
    logic [6:0]  next_byte;

    function automatic logic [15:0] f_sat(input logic [16:0] s);
        logic [15:0] r;
        if (s[16] != s[15]) begin
            r = s[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

    assign sum_x = {r_acc_x[15], r_acc_x} + {{9{r_held_x[7]}}, r_held_x};
    assign sum_y = {r_acc_y[15], r_acc_y} - {{9{r_byte[7]}}, r_byte};

    // clamp to a signed byte, keep what is left over
    assign x_hi  = !r_acc_x[15] && (r_acc_x[14:7] != 8'h00);
    assign x_lo  =  r_acc_x[15] && (r_acc_x[14:7] != 8'hFF);
    assign y_hi  = !r_acc_y[15] && (r_acc_y[14:7] != 8'h00);
    assign y_lo  =  r_acc_y[15] && (r_acc_y[14:7] != 8'hFF);
    assign cx    = x_hi ? 8'h7F : (x_lo ? 8'h80 : r_acc_x[7:0]);
    assign cy    = y_hi ? 8'h7F : (y_lo ? 8'h80 : r_acc_y[7:0]);
    assign rem_x = x_hi ? r_acc_x - 16'd127 : (x_lo ? r_acc_x + 16'd128 : 16'd0);
    assign rem_y = y_hi ? r_acc_y - 16'd127 : (y_lo ? r_acc_y + 16'd128 : 16'd0);

    assign report = r_host_en && ((r_cur_btn != r_sent_btn) || (r_acc_x != 16'd0)
                    || (r_acc_y != 16'd0) || r_force);

    always_comb begin
        n_mode     = i_cmd.cfg_wr ? i_cfg_protocol_mode : r_mode;
        n_pos      = r_pos;
        n_held_btn = r_held_btn;
        n_held_x   = r_held_x;
        n_acc_x    = r_acc_x;
        n_acc_y    = r_acc_y;
        n_cur_btn  = r_cur_btn;
        n_sent_btn = r_sent_btn;
        n_sent_mid = r_sent_mid;
        n_host_en  = r_host_en;
        n_force    = r_force;
        n_pkt      = r_pkt;
        n_greet    = r_greet;
        n_len      = r_len;
        if (i_cmd.exec) begin
            n_greet = 1'b0;
            n_len   = '0;
            unique case (r_func)
                C_FUNC_BYTE: begin
                    priority case (r_pos)
                        C_POS_X: begin
                            n_held_x = r_byte;
                            n_pos    = C_POS_Y;
                        end
                        C_POS_Y: begin
                            n_cur_btn = r_held_btn;
                            n_acc_x   = f_sat(sum_x);
                            n_acc_y   = f_sat(sum_y);
                            n_pos     = C_POS_BUTTONS;
                        end
                        default: begin
                            n_held_btn = r_byte[2:0];
                            n_pos      = C_POS_X;
                        end
                    endcase
                end
                C_FUNC_TICK: begin
                    if (report) begin
                        n_acc_x    = rem_x;
                        n_acc_y    = rem_y;
                        n_force    = 1'b0;
                        n_sent_btn = r_cur_btn;
                        n_pkt[0]   = {1'b1, r_cur_btn[0], r_cur_btn[1], cy[7:6], cx[7:6]};
                        n_pkt[1]   = {1'b0, cx[5:0]};
                        n_pkt[2]   = {1'b0, cy[5:0]};
                        n_len      = C_LEN_W'(3);
                        if (r_mode == C_MODE_EXTENDED) begin
                            n_pkt[3] = {2'b00, r_cur_btn[2], 4'b0000};
                            n_len    = C_LEN_W'(4);
                        end else if (r_cur_btn[2] || r_sent_mid) begin
                            n_pkt[3]   = {1'b0, r_cur_btn[2], 5'b00000};
                            n_len      = C_LEN_W'(4);
                            n_sent_mid = r_cur_btn[2];
                        end
                    end
                end
                C_FUNC_LINE: begin
                    n_host_en = !r_line;
                    n_force   = 1'b1;
                    if (!r_line) begin
                        if (r_mode == C_MODE_EXTENDED) begin
                            n_greet = 1'b1;
                            n_len   = C_LEN_W'(GREETING_LENGTH);
                        end else begin
                            n_pkt[0] = C_HELLO_0;
                            n_pkt[1] = C_HELLO_1;
                            n_len    = C_LEN_W'(2);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= C_MODE_THREE_BTN;
            r_pos      <= C_POS_BUTTONS;
            r_held_btn <= '0;
            r_held_x   <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
            r_cur_btn  <= '0;
            r_sent_btn <= '0;
            r_sent_mid <= 1'b0;
            r_host_en  <= 1'b0;
            r_force    <= 1'b0;
            r_greet    <= 1'b0;
            r_len      <= '0;
        end else begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_held_btn <= n_held_btn;
            r_held_x   <= n_held_x;
            r_acc_x    <= n_acc_x;
            r_acc_y    <= n_acc_y;
            r_cur_btn  <= n_cur_btn;
            r_sent_btn <= n_sent_btn;
            r_sent_mid <= n_sent_mid;
            r_host_en  <= n_host_en;
            r_force    <= n_force;
            r_greet    <= n_greet;
            r_len      <= n_len;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
        if (i_cmd.load) begin
            r_func <= i_func;
            r_byte <= i_ps2_byte;
            r_line <= i_host_line_high;
        end
        if (i_cmd.exec) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + C_IDX_W'(1);
        end
    end

    assign next_byte = r_greet ? C_GREET[r_idx] : r_pkt[r_idx[1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= next_byte;
            r_out_last <= o_sts.at_last;
        end
    end

    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.at_last  = ((C_LEN_W'(r_idx) + C_LEN_W'(1)) == r_len);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_serial_byte = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

### hdl/ps2_to_serial_mouse_translator_top.sv
// an item is taken, executed in the next cycle, and its first byte is
// emitted from the send state into the single output register; further
// bytes follow back to back while the output is not stalled. A new item
// is taken only after all bytes of the last one are emitted (up to 4 for
// a packet, GREETING_LENGTH for the identification string).
// reset: synchronous active-low, clears all translator state and the mode.
// ----------------------------------------------------------------------------
// ps2_to_serial_mouse_translator_top
// Converts PS/2 mouse packets into serial mouse reports and greetings.
// ----------------------------------------------------------------------------
module ps2_to_serial_mouse_translator_top import ps2sm_pkg::*; #(
    parameter int GREETING_LENGTH = C_GREETING_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_protocol_mode,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_ps2_byte,
    input  logic       i_host_line_high,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_serial_byte,
    output logic       o_last_of_run
);

    t_cmd cmd;
    t_sts sts;

    ps2sm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ps2sm_dp #(
        .GREETING_LENGTH (GREETING_LENGTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_protocol_mode (i_cfg_protocol_mode),
        .i_func              (i_func),
        .i_ps2_byte          (i_ps2_byte),
        .i_host_line_high    (i_host_line_high),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_serial_byte       (o_serial_byte),
        .o_last_of_run       (o_last_of_run)
    );

endmodule

### hdl/ps2sm_checker.sv
// ----------------------------------------------------------------------------
// ps2sm_checker
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
module ps2sm_checker import ps2sm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_func,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_serial_byte,
    input logic       o_last_of_run
);

    // one transaction in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in progress");

    // items other than ticks and line changes free the input again after the exec and send states
    a_silent_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func != C_FUNC_TICK && i_func != C_FUNC_LINE)
        |-> ##3 !o_in_stall)
        else $error("silent item did not release the input");

    // byte items taken while the output is idle produce no output
    a_byte_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func == C_FUNC_BYTE && !o_out_valid)
        |=> ##1 !o_out_valid)
        else $error("output appeared for a PS/2 byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_serial_byte) && $stable(o_last_of_run)))
        else $error("stalled output transaction changed");

endmodule

bind ps2_to_serial_mouse_translator_top ps2sm_checker u_ps2sm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_func        (i_func),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_serial_byte (o_serial_byte),
    .o_last_of_run (o_last_of_run)
);
